[hw/rtl/tmgf_pkg.sv]
// Shared widths, register indexes and the dimension clamp for the tamper map gap filler.
package tmgf_pkg;

  localparam int DIM_W     = 9;
  localparam int DIM_MAX   = 2 ** DIM_W - 1;
  localparam int POS_W     = 8;
  localparam int CNT_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COLS = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(128);

  // Map zero to one and anything above the limit to the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

[hw/rtl/tmgf_ram.sv]
// Generic simple dual-port RAM with registered, read-first output.
module tmgf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when both ports hit the same address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[hw/rtl/tamper_map_gap_fill.sv]
// Top level of the tamper map gap filler: line buffers, window and running counts.
// An item is captured in the window stage, then its result is loaded into the result register.
// Unstalled: one item per cycle; each column line buffer does one read and one write a cycle.
// A frame of rows*cols flags gives no result for its first cols+1 items and is
// flushed by cols+1 trailing drain items.
// Reset: synchronous, active low; clears control and restores 128 x 128; no clearing pass.
module tamper_map_gap_fill
  import tmgf_pkg::*;
#(
  parameter int MAX_BLOCK_ROWS = 256,
  parameter int MAX_BLOCK_COLS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_dirty_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_refined_dirty,
  output logic                 out_newly_marked,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic [CNT_W-1:0]     out_total_dirty,
  output logic [CNT_W-1:0]     out_added_count,
  output logic                 out_last_of_frame,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  localparam int COL_LIM = (MAX_BLOCK_COLS < DIM_MAX) ? MAX_BLOCK_COLS : DIM_MAX;
  localparam int ADDR_W  = $clog2(COL_LIM);

  // Configuration
  logic [DIM_W-1:0] rows_r, cols_r;
  logic             cfg_hit;

  // Input side counters
  logic [DIM_W:0]    fill_r;
  logic [DIM_W-1:0]  in_row_r;
  logic [ADDR_W-1:0] in_col_r;
  logic [DIM_W-1:0]  em_row_r;
  logic [ADDR_W-1:0] em_col_r;
  logic              smp1_r, smp2_r;

  // Window stage
  logic              s1_valid_r, s1_emit_r, s1_last_r;
  logic [DIM_W-1:0]  s1_row_r;
  logic [ADDR_W-1:0] s1_col_r;
  logic              s1_d0_r, s1_d1_r, s1_d2_r;
  logic              orig_cur_r;
  logic              rl_r, rl2_r, u_r, ul_r;

  // Result register
  logic              out_valid_r, refined_r, added_r, last_r;
  logic [POS_W-1:0]  row_r, col_r;
  logic [CNT_W-1:0]  total_r, count_added_r;

  logic              in_fire, s1_fire, em_fire;
  logic [DIM_W-1:0]  cols_m1, rows_m1;
  logic              fill_full, em_last, sample, in_col_last, em_col_last;
  logic              orig_rd, ref_rd;
  logic              up, down, left, right, u_sel, hit, refined, added, first;
  logic [DIM_W:0]    ref_p2;
  logic [ADDR_W-1:0] ref_rd_addr;

  assign cfg_hit = cfg_wr_en && (cfg_index == CFG_BLOCK_ROWS || cfg_index == CFG_BLOCK_COLS);

  assign cols_m1 = cols_r - DIM_W'(1);
  assign rows_m1 = rows_r - DIM_W'(1);

  // Handshake between stages
  assign s1_fire  = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ready);
  assign em_fire  = s1_fire && s1_emit_r;
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Input position decode
  assign fill_full   = (fill_r == ((DIM_W + 1)'(cols_r) + (DIM_W + 1)'(1)));
  assign in_col_last = (DIM_W'(in_col_r) == cols_m1);
  assign em_col_last = (DIM_W'(em_col_r) == cols_m1);
  assign em_last     = fill_full && (em_row_r == rows_m1) && em_col_last;
  assign sample      = (in_row_r < rows_r) && in_dirty_in;

  // Hold configuration; any valid write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= clamp_dim(DIM_RESET, MAX_BLOCK_ROWS);
      cols_r <= clamp_dim(DIM_RESET, COL_LIM);
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_BLOCK_ROWS) begin
        rows_r <= clamp_dim(cfg_wdata, MAX_BLOCK_ROWS);
      end else if (cfg_index == CFG_BLOCK_COLS) begin
        cols_r <= clamp_dim(cfg_wdata, COL_LIM);
      end
    end
  end

  // Advance input and emission positions per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      fill_r   <= '0;
      in_row_r <= '0;
      in_col_r <= '0;
      em_row_r <= '0;
      em_col_r <= '0;
    end else if (in_fire) begin
      if (em_last) begin
        fill_r   <= '0;
        in_row_r <= '0;
        in_col_r <= '0;
        em_row_r <= '0;
        em_col_r <= '0;
      end else begin
        if (in_col_last) begin
          in_col_r <= '0;
          if (in_row_r < rows_r) begin
            in_row_r <= in_row_r + DIM_W'(1);
          end
        end else begin
          in_col_r <= in_col_r + ADDR_W'(1);
        end
        if (!fill_full) begin
          fill_r <= fill_r + (DIM_W + 1)'(1);
        end else if (em_col_last) begin
          em_col_r <= '0;
          em_row_r <= em_row_r + DIM_W'(1);
        end else begin
          em_col_r <= em_col_r + ADDR_W'(1);
        end
      end
    end
  end

  // Original flags one row back, addressed by column
  tmgf_ram #(
    .WIDTH (1),
    .DEPTH (COL_LIM)
  ) u_orig_ram (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (in_col_r),
    .wr_data (sample),
    .rd_en   (in_fire),
    .rd_addr (in_col_r),
    .rd_data (orig_rd)
  );

  // Capture the request into the window stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_emit_r <= fill_full;
      s1_last_r <= em_last;
      s1_row_r  <= em_row_r;
      s1_col_r  <= em_col_r;
      s1_d0_r   <= sample;
      s1_d1_r   <= smp1_r;
      s1_d2_r   <= smp2_r;
      smp1_r    <= sample;
      smp2_r    <= smp1_r;
    end
    if (s1_fire) begin
      orig_cur_r <= orig_rd;
    end
  end

  // Neighbor availability of the emitted block
  assign up    = (s1_row_r != '0);
  assign down  = (s1_row_r != rows_m1);
  assign left  = (s1_col_r != '0);
  assign right = (DIM_W'(s1_col_r) != cols_m1);

  // Upper neighbor: narrow maps take it from the recent refined flags
  always_comb begin
    case (cols_r)
      DIM_W'(1): u_sel = rl_r;
      DIM_W'(2): u_sel = rl2_r;
      default:   u_sel = u_r;
    endcase
  end

  // Pair tests
  assign hit = (up && down && ((left && right && ul_r && s1_d0_r) ||
                               (u_sel && s1_d1_r) ||
                               (left && right && ref_rd && s1_d2_r))) ||
               (left && right && rl_r && orig_rd);
  assign refined = orig_cur_r || hit;
  assign added   = !orig_cur_r && hit;
  assign first   = (s1_row_r == '0) && (s1_col_r == '0);

  // Refined row buffer: fetch the upper-right flag of the next block
  assign ref_p2 = (DIM_W + 1)'(s1_col_r) + (DIM_W + 1)'(2);
  always_comb begin
    if (ref_p2 >= (DIM_W + 1)'(cols_r)) begin
      ref_rd_addr = ADDR_W'(ref_p2 - (DIM_W + 1)'(cols_r));
    end else begin
      ref_rd_addr = ADDR_W'(ref_p2);
    end
  end

  tmgf_ram #(
    .WIDTH (1),
    .DEPTH (COL_LIM)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (em_fire),
    .wr_addr (s1_col_r),
    .wr_data (refined),
    .rd_en   (em_fire),
    .rd_addr (ref_rd_addr),
    .rd_data (ref_rd)
  );

  // Shift the refined window and load the result
  always_ff @(posedge clk) begin
    if (em_fire) begin
      rl_r          <= refined;
      rl2_r         <= rl_r;
      u_r           <= ref_rd;
      ul_r          <= u_r;
      refined_r     <= refined;
      added_r       <= added;
      last_r        <= s1_last_r;
      row_r         <= POS_W'(s1_row_r);
      col_r         <= POS_W'(s1_col_r);
      total_r       <= (first ? '0 : total_r) + CNT_W'(refined);
      count_added_r <= (first ? '0 : count_added_r) + CNT_W'(added);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (em_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_refined_dirty = refined_r;
  assign out_newly_marked  = added_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_total_dirty   = total_r;
  assign out_added_count   = count_added_r;
  assign out_last_of_frame = last_r;

endmodule

[hw/rtl/tmgf_chk.sv]
// Port-level checks on the result channel of the tamper map gap filler, with bind.
module tmgf_chk
  import tmgf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_refined_dirty,
  input logic             out_newly_marked,
  input logic [POS_W-1:0] out_row,
  input logic [POS_W-1:0] out_col,
  input logic [CNT_W-1:0] out_total_dirty,
  input logic [CNT_W-1:0] out_added_count,
  input logic             out_last_of_frame
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_refined_dirty) &&
      $stable(out_newly_marked) && $stable(out_row) && $stable(out_col) &&
      $stable(out_total_dirty) && $stable(out_added_count) && $stable(out_last_of_frame))
    else $error("result changed while stalled");

  // A newly marked block must come out tampered
  a_added_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_newly_marked |-> out_refined_dirty)
    else $error("newly marked block not flagged as tampered");

  // Drop any result after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tamper_map_gap_fill tmgf_chk u_tmgf_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_refined_dirty (out_refined_dirty),
  .out_newly_marked  (out_newly_marked),
  .out_row           (out_row),
  .out_col           (out_col),
  .out_total_dirty   (out_total_dirty),
  .out_added_count   (out_added_count),
  .out_last_of_frame (out_last_of_frame)
);

[tb/sv/tb_top.sv]
// Testbench for the tamper map gap filler: raster frames checked against a local gap-fill predictor.
`timescale 1ns / 1ps

module tb_top;
  import tmgf_pkg::*;

  localparam int MAX_ROWS      = 256;
  localparam int MAX_COLS      = 256;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int RAND_ITEMS    = 500;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_LIMIT_NS  = 4_000_000;

  // Register indexes outside the list; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct {
    logic             refined;
    logic             marked;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] added;
    logic             last;
  } flag_result_t;

  // Gap-fill predictor and queue of refined flags still owed by the block
  class flag_scoreboard;
    int unsigned  rows;
    int unsigned  cols;
    bit           orig_dly [MAX_COLS+2];
    bit           ref_hist [MAX_COLS+1];
    int unsigned  in_pos;
    int unsigned  emit_pos;
    int unsigned  run_total;
    int unsigned  run_added;
    flag_result_t owed_q [$];
    int unsigned  fail_count;

    function new();
      rows = DIM_RESET;
      cols = DIM_RESET;
      fail_count = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      foreach (orig_dly[i]) orig_dly[i] = 1'b0;
      foreach (ref_hist[i]) ref_hist[i] = 1'b0;
      in_pos = 0;
      emit_pos = 0;
      run_total = 0;
      run_added = 0;
    endfunction

    function int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == '0) return 1;
      if (int'(v) > lim) return lim;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == CFG_BLOCK_ROWS) begin
        rows = fit_dim(val, MAX_ROWS);
        restart_frame();
      end else if (idx == CFG_BLOCK_COLS) begin
        cols = fit_dim(val, MAX_COLS);
        restart_frame();
      end
    endfunction

    // Shift one accepted flag in and predict the refined flag it releases, if any
    function void take_flag(bit flag);
      int unsigned  area;
      int unsigned  e;
      int unsigned  r;
      int unsigned  c;
      bit           fresh;
      bit           orig;
      bit           hit;
      bit           up;
      bit           down;
      bit           left;
      bit           right;
      flag_result_t res;
      area = rows * cols;
      fresh = (in_pos < area) ? flag : 1'b0;
      for (int i = MAX_COLS + 1; i > 0; i--) orig_dly[i] = orig_dly[i-1];
      orig_dly[0] = fresh;
      if (in_pos < area + cols + 1) in_pos++;
      e = emit_pos;
      if (e >= area || in_pos < e + cols + 2) return;
      r = e / cols;
      c = e % cols;
      up = (r >= 1);
      down = (r + 1 < rows);
      left = (c >= 1);
      right = (c + 1 < cols);
      // Upper neighbours come from refined history, lower ones from the original delay line
      orig = orig_dly[cols+1];
      hit = 1'b0;
      if (up && down) begin
        if (ref_hist[cols-1] && orig_dly[1]) hit = 1'b1;
        if (left && right) begin
          if (ref_hist[cols] && orig_dly[0]) hit = 1'b1;
          if (ref_hist[cols-2] && orig_dly[2]) hit = 1'b1;
        end
      end
      if (left && right) begin
        if (ref_hist[0] && orig_dly[cols]) hit = 1'b1;
      end
      if (e == 0) begin
        run_total = 0;
        run_added = 0;
      end
      res.refined = orig | hit;
      res.marked = !orig && hit;
      run_total += res.refined;
      run_added += res.marked;
      for (int i = MAX_COLS; i > 0; i--) ref_hist[i] = ref_hist[i-1];
      ref_hist[0] = res.refined;
      res.row = POS_W'(r);
      res.col = POS_W'(c);
      res.total = CNT_W'(run_total);
      res.added = CNT_W'(run_added);
      res.last = (e + 1 == area);
      owed_q.push_back(res);
      if (res.last) begin
        in_pos = 0;
        emit_pos = 0;
      end else begin
        emit_pos = e + 1;
      end
    endfunction

    function void cmp_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        fail_count++;
      end
    endfunction

    function void check_flag(flag_result_t got);
      flag_result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result at row %0d col %0d", got.row, got.col);
        fail_count++;
        return;
      end
      want = owed_q.pop_front();
      cmp_field("refined_dirty", want.refined, got.refined);
      cmp_field("newly_marked", want.marked, got.marked);
      cmp_field("out_row", want.row, got.row);
      cmp_field("out_col", want.col, got.col);
      cmp_field("total_dirty", want.total, got.total);
      cmp_field("added_count", want.added, got.added);
      cmp_field("last_of_frame", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_dirty_in = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_refined_dirty;
  logic                 out_newly_marked;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;
  logic [CNT_W-1:0]     out_total_dirty;
  logic [CNT_W-1:0]     out_added_count;
  logic                 out_last_of_frame;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;

  flag_scoreboard sb = new();
  int unsigned    tx_idle_pct = 6;
  int unsigned    rx_idle_pct = 68;
  int unsigned    hold_req = 0;
  int unsigned    flags_sent = 0;

  tamper_map_gap_fill #(
    .MAX_BLOCK_ROWS(MAX_ROWS),
    .MAX_BLOCK_COLS(MAX_COLS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_dirty_in      (in_dirty_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_refined_dirty(out_refined_dirty),
    .out_newly_marked (out_newly_marked),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_total_dirty  (out_total_dirty),
    .out_added_count  (out_added_count),
    .out_last_of_frame(out_last_of_frame),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #RUN_LIMIT_NS;
    $display("Test completed with failures");
    $finish;
  end

  // Accept refined flags; stall at random and on a pressure request
  initial begin : result_sink
    flag_result_t got;
    int unsigned  hold_left;
    int unsigned  hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.refined = out_refined_dirty;
        got.marked = out_newly_marked;
        got.row = out_row;
        got.col = out_col;
        got.total = out_total_dirty;
        got.added = out_added_count;
        got.last = out_last_of_frame;
        sb.check_flag(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one flag request and hold it until accepted
  task automatic send_flag(input bit flag);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dirty_in <= flag;
    do @(posedge clk); while (!in_ready);
    sb.take_flag(flag);
    flags_sent++;
  endtask

  // Send a flag pattern, most significant bit first
  task automatic send_pattern(input logic [31:0] pat, input int n);
    for (int i = n - 1; i >= 0; i--) send_flag(pat[i]);
  endtask

  // Drop valid and wait until every owed result is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Reprogram the map size on an idle block, sometimes with a stray write to a spare index
  task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
    settle();
    write_reg(CFG_BLOCK_ROWS, r);
    write_reg(CFG_BLOCK_COLS, c);
    if ($urandom_range(2) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, DIM_W'($urandom));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Stream whole frames with drain, or a frame cut short at random
  task automatic send_frames(input int unsigned nframes, input int unsigned density,
                             input bit cut);
    int unsigned area;
    int unsigned span;
    int unsigned count;
    area = sb.rows * sb.cols;
    span = area + sb.cols + 1;
    count = cut ? $urandom_range(span - 1, 1) : span * nframes;
    for (int unsigned i = 0; i < count; i++) begin
      if ((i % span) < area) send_flag($urandom_range(99) < density);
      else send_flag($urandom_range(1));
    end
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      goal;
    int unsigned      third;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run the reset map size far enough to see the first results come out
    for (int i = 0; i < 140; i++) send_flag($urandom_range(1));

    // Corners around a clean center, then drain with set flags that must be ignored
    set_dims(DIM_W'(3), DIM_W'(3));
    send_pattern(32'b1010_0010_1111_1, 13);
    // Two rows: only the horizontal pair can fill
    set_dims(DIM_W'(2), DIM_W'(3));
    send_pattern(32'b1010_1011_11, 10);

    goal = flags_sent + RAND_ITEMS;
    third = RAND_ITEMS / 3;
    phase = 0;
    while (flags_sent < goal) begin
      phase++;
      // Swap idling sides after a third, then run without idling and force a long stall
      if (flags_sent + 2 * third >= goal && tx_idle_pct == 6) begin
        tx_idle_pct = 68;
        rx_idle_pct = 6;
      end else if (flags_sent + third >= goal && tx_idle_pct != 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req++;
      end
      case (phase)
        3: set_dims('1, DIM_W'(1));
        6: set_dims('0, DIM_W'($urandom_range(511, 257)));
        9: set_dims(DIM_W'(1), DIM_W'(MAX_COLS));
        default: begin
          if ($urandom_range(4) != 0) begin
            r = ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom_range(8, 1));
            c = ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom_range(8, 1));
            set_dims(r, c);
          end
        end
      endcase
      send_frames((sb.rows * sb.cols > 64) ? 1 : $urandom_range(3, 1),
                  $urandom_range(80, 20), ($urandom_range(5) == 0));
    end

    settle();
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
